// ===== src/hcd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcd_pkg
// Shared types and constants for the hyperedge contraction block.
// ----------------------------------------------------------------------------
package hcd_pkg;

  localparam int VERTEX_SLOTS  = 4096;
  localparam int VW            = 12;
  localparam int MAX_EDGE_PINS = 32;
  localparam int PIW           = 5;
  localparam int PCW           = 6;
  localparam int EDGE_SLOTS    = 4096;
  localparam int EW            = 12;
  localparam int ETW           = 13;
  localparam int PIN_SLOTS     = 16384;
  localparam int PAW           = 14;
  localparam int PTW           = 15;
  localparam int CVW           = 13;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_PIN   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] KIND_PIN   = 2'd0;
  localparam logic [1:0] KIND_MERGE = 2'd1;
  localparam logic [1:0] KIND_DROP  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Bucket head value for an empty bucket.
  localparam logic [ETW-1:0] NO_EDGE = {1'b1, {EW{1'b0}}};

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_MAP, S_SCAN, S_FIN, S_HEAD, S_NEXT, S_OFF0, S_OFF1,
    S_CMP, S_FULL, S_ST0, S_ST1, S_EMIT, S_ONE
  } state_t;

  typedef struct packed {
    logic [1:0]    cmd;
    logic [VW-1:0] fine_vertex;
    logic [VW-1:0] mapped_vertex;
    logic [15:0]   edge_weight;
    logic          last_pin;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]    kind;
    logic [EW-1:0] edge_index;
    logic [VW-1:0] coarse_pin;
    logic [15:0]   weight;
    logic          last;
  } out_beat_t;

  typedef struct packed {
    logic           clr;
    logic           ins;
    logic [PCW-1:0] pos;
    logic [VW-1:0]  val;
    logic [PIW-1:0] rd_idx;
  } pend_ctl_t;

  typedef struct packed {
    logic [PCW-1:0] count;
    logic [VW-1:0]  rd_data;
    logic [VW-1:0]  first;
  } pend_sts_t;

endpackage

// ===== src/hcd_pending.sv =====
// ----------------------------------------------------------------------------
// hcd_pending
// Sorted buffer of the coarse pins of the edge being assembled.
// ----------------------------------------------------------------------------
module hcd_pending (
  input  logic              clk,
  input  logic              rst_n,
  input  hcd_pkg::pend_ctl_t ctl,
  output hcd_pkg::pend_sts_t sts
);

  logic [hcd_pkg::VW-1:0]  pins_r [hcd_pkg::MAX_EDGE_PINS];
  logic [hcd_pkg::PCW-1:0] count_r;

  // Fill count; entries beyond it are never read.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      count_r <= '0;
    end else if (ctl.ins) begin
      count_r <= count_r + 1'b1;
    end
  end

  // Insertion shifts every entry above the slot up by one.
  always_ff @(posedge clk) begin
    for (int j = 0; j < hcd_pkg::MAX_EDGE_PINS; j++) begin
      if (ctl.ins) begin
        if (hcd_pkg::PCW'(j) == ctl.pos) begin
          pins_r[j] <= ctl.val;
        end else if (j > 0 && hcd_pkg::PCW'(j) > ctl.pos) begin
          pins_r[j] <= pins_r[(j > 0) ? j - 1 : 0];
        end
      end
    end
  end

  assign sts.count   = count_r;
  assign sts.rd_data = pins_r[ctl.rd_idx];
  assign sts.first   = pins_r[0];

endmodule

// ===== src/hyperedge_contraction_dedup.sv =====
// ----------------------------------------------------------------------------
// hyperedge_contraction_dedup
// Maps fine hyperedge pins to coarse vertices, builds the sorted contracted
// edge, and either drops it, reports a merge with a stored duplicate, reports
// an error, or stores and emits it.
//
//   channel | direction | handshake       | beat
//   in_     | input     | valid / stall   | in_beat_t command
//   out_    | output    | valid / stall   | out_beat_t result
//   cfg_    | input     | valid / ready   | coarse vertex count
//
// One item is worked on at a time. A map load or a clear is accepted in the
// idle state; a pin is mapped and then the pending entries are scanned for its
// slot. A last pin then classifies the edge and walks its bucket (head, offsets
// and a compare per pin of each candidate edge); a stored edge is written and
// emitted pin by pin, other outcomes give a single result beat. After reset and
// after a clear all 4096 bucket heads are swept before items are taken. Output
// stalls hold the sequencer in its emit states.
// ----------------------------------------------------------------------------
module hyperedge_contraction_dedup (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  hcd_pkg::in_beat_t       in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output hcd_pkg::out_beat_t      out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [hcd_pkg::CVW-1:0] cfg_data
);

  // Memories.
  logic [hcd_pkg::VW-1:0]  vmap  [hcd_pkg::VERTEX_SLOTS];
  logic [hcd_pkg::ETW-1:0] bhead [hcd_pkg::VERTEX_SLOTS];
  logic [hcd_pkg::ETW-1:0] bnext [hcd_pkg::EDGE_SLOTS];
  logic [hcd_pkg::PTW-1:0] offs  [hcd_pkg::EDGE_SLOTS + 1];
  logic [hcd_pkg::VW-1:0]  cpins [hcd_pkg::PIN_SLOTS];

  logic [hcd_pkg::VW-1:0]  vmap_q, cpins_q;
  logic [hcd_pkg::ETW-1:0] bhead_q, bnext_q;
  logic [hcd_pkg::PTW-1:0] offs_q;

  logic                    vmap_we, bh_we, bn_we, offs_we, cp_we;
  logic [hcd_pkg::VW-1:0]  vmap_ra, bh_wa, bh_ra;
  logic [hcd_pkg::EW-1:0]  bn_ra;
  logic [hcd_pkg::ETW-1:0] bh_wd, offs_wa, offs_ra;
  logic [hcd_pkg::PTW-1:0] offs_wd;
  logic [hcd_pkg::PAW-1:0] cp_wa, cp_ra;

  // Control and datapath registers.
  hcd_pkg::state_t         state_r, state_nxt;
  logic [hcd_pkg::CVW-1:0] cvc_r;
  logic                    ovf_r, lastp_r;
  logic [15:0]             wt_r;
  logic [hcd_pkg::VW-1:0]  v_r;
  logic [hcd_pkg::PCW-1:0] pos_r, i_r;
  logic [hcd_pkg::EW-1:0]  e_r;
  logic [hcd_pkg::ETW-1:0] head_r;
  logic [hcd_pkg::PTW-1:0] start_r, pin_total_r;
  logic [hcd_pkg::ETW-1:0] edge_total_r;
  logic [hcd_pkg::VW-1:0]  clr_r;
  logic [1:0]              res_kind_r;
  logic [hcd_pkg::EW-1:0]  res_idx_r;
  logic [15:0]             res_wt_r;
  logic                    out_valid_r;
  hcd_pkg::out_beat_t      out_data_r;

  hcd_pkg::pend_ctl_t      pctl;
  hcd_pkg::pend_sts_t      psts;

  logic                    accept, slot_free, out_load;
  hcd_pkg::out_beat_t      out_nxt;
  logic [hcd_pkg::ETW-1:0] e_in;
  logic                    e_end, scan_in, scan_lt, scan_eq, v_bad, full;
  logic [hcd_pkg::PTW-1:0] len;
  logic                    cmp_eq, cmp_last, emit_last;

  hcd_pending u_pending (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (pctl),
    .sts   (psts)
  );

  assign accept    = in_valid && (state_r == hcd_pkg::S_IDLE);
  assign in_stall  = (state_r != hcd_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Shared conditions.
  assign e_in      = (state_r == hcd_pkg::S_HEAD) ? bhead_q : bnext_q;
  assign e_end     = e_in[hcd_pkg::ETW-1] || (e_in >= edge_total_r);
  assign scan_in   = pos_r < psts.count;
  assign scan_lt   = scan_in && (psts.rd_data < v_r);
  assign scan_eq   = scan_in && (psts.rd_data == v_r);
  assign v_bad     = {1'b0, vmap_q} >= cvc_r;
  assign len       = offs_q - start_r;
  assign cmp_eq    = cpins_q == psts.rd_data;
  assign cmp_last  = (i_r + 1'b1) == psts.count;
  assign emit_last = (i_r + 1'b1) == psts.count;
  assign full      = (edge_total_r >= hcd_pkg::ETW'(hcd_pkg::EDGE_SLOTS)) ||
                     ({{(hcd_pkg::PTW-hcd_pkg::PCW){1'b0}}, psts.count} >
                      (hcd_pkg::PTW'(hcd_pkg::PIN_SLOTS) - pin_total_r));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hcd_pkg::S_CLR: begin
        if (clr_r == '1) state_nxt = hcd_pkg::S_IDLE;
      end
      hcd_pkg::S_IDLE: begin
        if (accept) begin
          if (in_data.cmd == hcd_pkg::CMD_CLEAR) begin
            state_nxt = hcd_pkg::S_CLR;
          end else if (in_data.cmd == hcd_pkg::CMD_PIN) begin
            if (!ovf_r) state_nxt = hcd_pkg::S_MAP;
            else if (in_data.last_pin) state_nxt = hcd_pkg::S_FIN;
          end
        end
      end
      hcd_pkg::S_MAP: begin
        if (!v_bad) state_nxt = hcd_pkg::S_SCAN;
        else state_nxt = lastp_r ? hcd_pkg::S_FIN : hcd_pkg::S_IDLE;
      end
      hcd_pkg::S_SCAN: begin
        if (!scan_lt) state_nxt = lastp_r ? hcd_pkg::S_FIN : hcd_pkg::S_IDLE;
      end
      hcd_pkg::S_FIN: begin
        if (ovf_r || psts.count < hcd_pkg::PCW'(2)) state_nxt = hcd_pkg::S_ONE;
        else state_nxt = hcd_pkg::S_HEAD;
      end
      hcd_pkg::S_HEAD, hcd_pkg::S_NEXT: begin
        state_nxt = e_end ? hcd_pkg::S_FULL : hcd_pkg::S_OFF0;
      end
      hcd_pkg::S_OFF0: state_nxt = hcd_pkg::S_OFF1;
      hcd_pkg::S_OFF1: begin
        if (len != {{(hcd_pkg::PTW-hcd_pkg::PCW){1'b0}}, psts.count}) begin
          state_nxt = hcd_pkg::S_NEXT;
        end else begin
          state_nxt = hcd_pkg::S_CMP;
        end
      end
      hcd_pkg::S_CMP: begin
        if (!cmp_eq) state_nxt = hcd_pkg::S_NEXT;
        else if (cmp_last) state_nxt = hcd_pkg::S_ONE;
      end
      hcd_pkg::S_FULL: state_nxt = full ? hcd_pkg::S_ONE : hcd_pkg::S_ST0;
      hcd_pkg::S_ST0:  state_nxt = hcd_pkg::S_ST1;
      hcd_pkg::S_ST1:  state_nxt = hcd_pkg::S_EMIT;
      hcd_pkg::S_EMIT: begin
        if (slot_free && emit_last) state_nxt = hcd_pkg::S_IDLE;
      end
      hcd_pkg::S_ONE: begin
        if (slot_free) state_nxt = hcd_pkg::S_IDLE;
      end
      default: state_nxt = hcd_pkg::S_CLR;
    endcase
  end

  // Memory ports, pending buffer control and result beats.
  always_comb begin
    vmap_we = 1'b0;
    vmap_ra = in_data.fine_vertex;
    bh_we   = 1'b0;
    bh_wa   = clr_r;
    bh_wd   = hcd_pkg::NO_EDGE;
    bh_ra   = psts.first;
    bn_we   = 1'b0;
    bn_ra   = e_r;
    offs_we = 1'b0;
    offs_wa = edge_total_r;
    offs_wd = pin_total_r;
    offs_ra = {1'b0, e_in[hcd_pkg::EW-1:0]};
    cp_we   = 1'b0;
    cp_wa   = pin_total_r[hcd_pkg::PAW-1:0] +
              {{(hcd_pkg::PAW-hcd_pkg::PCW){1'b0}}, i_r};
    cp_ra   = start_r[hcd_pkg::PAW-1:0];
    pctl    = '0;
    pctl.pos    = pos_r;
    pctl.val    = v_r;
    pctl.rd_idx = pos_r[hcd_pkg::PIW-1:0];
    out_load = 1'b0;
    out_nxt  = '0;
    unique case (state_r)
      hcd_pkg::S_CLR: bh_we = 1'b1;
      hcd_pkg::S_IDLE: begin
        vmap_we = accept && (in_data.cmd == hcd_pkg::CMD_LOAD);
        pctl.clr = accept && (in_data.cmd == hcd_pkg::CMD_CLEAR);
      end
      hcd_pkg::S_SCAN: begin
        pctl.ins = !scan_lt && !scan_eq &&
                   (psts.count < hcd_pkg::PCW'(hcd_pkg::MAX_EDGE_PINS));
      end
      hcd_pkg::S_OFF0: offs_ra = {1'b0, e_r} + 1'b1;
      hcd_pkg::S_OFF1: pctl.rd_idx = '0;
      hcd_pkg::S_CMP: begin
        pctl.rd_idx = i_r[hcd_pkg::PIW-1:0];
        cp_ra = start_r[hcd_pkg::PAW-1:0] +
                {{(hcd_pkg::PAW-hcd_pkg::PCW){1'b0}}, i_r} + 1'b1;
      end
      hcd_pkg::S_ST0: begin
        offs_we = 1'b1;
        bn_we   = 1'b1;
        bh_we   = 1'b1;
        bh_wa   = psts.first;
        bh_wd   = edge_total_r;
      end
      hcd_pkg::S_ST1: begin
        offs_we = 1'b1;
        offs_wa = edge_total_r + 1'b1;
        offs_wd = pin_total_r + {{(hcd_pkg::PTW-hcd_pkg::PCW){1'b0}}, psts.count};
      end
      hcd_pkg::S_EMIT: begin
        pctl.rd_idx = i_r[hcd_pkg::PIW-1:0];
        if (slot_free) begin
          cp_we    = 1'b1;
          out_load = 1'b1;
          out_nxt.kind       = hcd_pkg::KIND_PIN;
          out_nxt.edge_index = edge_total_r[hcd_pkg::EW-1:0];
          out_nxt.coarse_pin = psts.rd_data;
          out_nxt.weight     = wt_r;
          out_nxt.last       = emit_last;
          pctl.clr           = emit_last;
        end
      end
      hcd_pkg::S_ONE: begin
        if (slot_free) begin
          out_load = 1'b1;
          out_nxt.kind       = res_kind_r;
          out_nxt.edge_index = res_idx_r;
          out_nxt.weight     = res_wt_r;
          out_nxt.last       = 1'b1;
          pctl.clr           = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Synchronous memories with registered read data.
  always_ff @(posedge clk) begin
    if (vmap_we) vmap[in_data.fine_vertex] <= in_data.mapped_vertex;
    vmap_q <= vmap[vmap_ra];
  end

  always_ff @(posedge clk) begin
    if (bh_we) bhead[bh_wa] <= bh_wd;
    bhead_q <= bhead[bh_ra];
  end

  always_ff @(posedge clk) begin
    if (bn_we) bnext[edge_total_r[hcd_pkg::EW-1:0]] <= head_r;
    bnext_q <= bnext[bn_ra];
  end

  always_ff @(posedge clk) begin
    if (offs_we) offs[offs_wa] <= offs_wd;
    offs_q <= offs[offs_ra];
  end

  always_ff @(posedge clk) begin
    if (cp_we) cpins[cp_wa] <= psts.rd_data;
    cpins_q <= cpins[cp_ra];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= hcd_pkg::S_CLR;
      cvc_r        <= hcd_pkg::CVW'(hcd_pkg::VERTEX_SLOTS);
      ovf_r        <= 1'b0;
      clr_r        <= '0;
      edge_total_r <= '0;
      pin_total_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) cvc_r <= cfg_data;
      if (state_r == hcd_pkg::S_CLR) clr_r <= clr_r + 1'b1;
      if (pctl.clr) ovf_r <= 1'b0;
      else if ((state_r == hcd_pkg::S_MAP && v_bad) ||
               (state_r == hcd_pkg::S_SCAN && !scan_lt && !scan_eq &&
                psts.count >= hcd_pkg::PCW'(hcd_pkg::MAX_EDGE_PINS))) begin
        ovf_r <= 1'b1;
      end
      if (accept && in_data.cmd == hcd_pkg::CMD_CLEAR) begin
        clr_r        <= '0;
        edge_total_r <= '0;
        pin_total_r  <= '0;
      end
      if (state_r == hcd_pkg::S_EMIT && slot_free && emit_last) begin
        edge_total_r <= edge_total_r + 1'b1;
        pin_total_r  <= pin_total_r +
                        {{(hcd_pkg::PTW-hcd_pkg::PCW){1'b0}}, psts.count};
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= out_nxt;
    if (accept) begin
      wt_r    <= in_data.edge_weight;
      lastp_r <= in_data.last_pin;
    end
    unique case (state_r)
      hcd_pkg::S_MAP: begin
        v_r   <= vmap_q;
        pos_r <= '0;
      end
      hcd_pkg::S_SCAN: if (scan_lt) pos_r <= pos_r + 1'b1;
      hcd_pkg::S_FIN: begin
        res_idx_r  <= '0;
        res_wt_r   <= '0;
        res_kind_r <= ovf_r ? hcd_pkg::KIND_ERROR : hcd_pkg::KIND_DROP;
      end
      hcd_pkg::S_HEAD, hcd_pkg::S_NEXT: begin
        e_r <= e_in[hcd_pkg::EW-1:0];
        if (state_r == hcd_pkg::S_HEAD) head_r <= bhead_q;
      end
      hcd_pkg::S_OFF0: start_r <= offs_q;
      hcd_pkg::S_OFF1: i_r <= '0;
      hcd_pkg::S_CMP: begin
        i_r        <= i_r + 1'b1;
        res_kind_r <= hcd_pkg::KIND_MERGE;
        res_idx_r  <= e_r;
        res_wt_r   <= wt_r;
      end
      hcd_pkg::S_FULL: begin
        res_kind_r <= hcd_pkg::KIND_ERROR;
        res_idx_r  <= '0;
        res_wt_r   <= '0;
        i_r        <= '0;
      end
      hcd_pkg::S_EMIT: if (slot_free) i_r <= i_r + 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hyperedge contraction block: map loads, pins
// and clears are predicted in the bench and every result beat is compared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  // Command code that the block ignores.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  hcd_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  hcd_pkg::out_beat_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [hcd_pkg::CVW-1:0] cfg_data = '0;

  hyperedge_contraction_dedup dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow state of the contraction.
  logic [hcd_pkg::VW-1:0] map_shadow [hcd_pkg::VERTEX_SLOTS];
  logic [hcd_pkg::VW-1:0] pend_pins [hcd_pkg::MAX_EDGE_PINS];
  int unsigned    pend_n;
  bit             pend_bad;
  logic [hcd_pkg::VW-1:0] store_pins [hcd_pkg::PIN_SLOTS];
  int unsigned    edge_off [hcd_pkg::EDGE_SLOTS+1];
  int unsigned    edge_n, pin_n;
  int unsigned    bhead [hcd_pkg::VERTEX_SLOTS];
  int unsigned    bnext [hcd_pkg::EDGE_SLOTS];
  int unsigned    vcount;
  localparam int unsigned EMPTY = 32'hFFFF_FFFF;

  hcd_pkg::in_beat_t  cmd_queue [$];
  hcd_pkg::out_beat_t result_queue [$];
  int errors = 0;
  int sent = 0;
  bit hold_input = 1'b0;
  bit held = 1'b0;

  function automatic hcd_pkg::out_beat_t mk(logic [1:0] k, int unsigned e,
                                            int unsigned p, int unsigned w, bit l);
    hcd_pkg::out_beat_t r;
    r.kind = k; r.edge_index = e[hcd_pkg::EW-1:0]; r.coarse_pin = p[hcd_pkg::VW-1:0];
    r.weight = w[15:0]; r.last = l;
    return r;
  endfunction

  task automatic clear_shadow();
    edge_n = 0; pin_n = 0; edge_off[0] = 0;
    for (int i = 0; i < hcd_pkg::VERTEX_SLOTS; i++) bhead[i] = EMPTY;
    pend_n = 0; pend_bad = 0;
  endtask

  task automatic add_pending(int unsigned fine);
    int unsigned v, pos;
    if (pend_bad) return;
    v = map_shadow[fine];
    if (v >= vcount) begin
      pend_bad = 1; return;
    end
    pos = 0;
    while (pos < pend_n && pend_pins[pos] < v) pos++;
    if (pos < pend_n && pend_pins[pos] == v) return;
    if (pend_n >= hcd_pkg::MAX_EDGE_PINS) begin
      pend_bad = 1; return;
    end
    for (int i = pend_n; i > pos; i--) pend_pins[i] = pend_pins[i-1];
    pend_pins[pos] = v[hcd_pkg::VW-1:0];
    pend_n++;
  endtask

  function automatic bit matches_stored(int unsigned e);
    int unsigned s, len;
    s = edge_off[e];
    len = edge_off[e+1] - s;
    if (len != pend_n) return 0;
    for (int i = 0; i < len; i++)
      if (store_pins[s+i] != pend_pins[i]) return 0;
    return 1;
  endfunction

  task automatic close_edge(int unsigned wt);
    int unsigned first, e, steps;
    if (pend_bad) begin
      result_queue.push_back(mk(hcd_pkg::KIND_ERROR, 0, 0, 0, 1)); return;
    end
    if (pend_n < 2) begin
      result_queue.push_back(mk(hcd_pkg::KIND_DROP, 0, 0, 0, 1)); return;
    end
    first = pend_pins[0];
    e = bhead[first];
    steps = 0;
    while (e != EMPTY && e < edge_n && steps < edge_n) begin
      if (matches_stored(e)) begin
        result_queue.push_back(mk(hcd_pkg::KIND_MERGE, e, 0, wt, 1)); return;
      end
      e = bnext[e];
      steps++;
    end
    if (edge_n >= hcd_pkg::EDGE_SLOTS || pend_n > hcd_pkg::PIN_SLOTS - pin_n) begin
      result_queue.push_back(mk(hcd_pkg::KIND_ERROR, 0, 0, 0, 1)); return;
    end
    e = edge_n;
    for (int i = 0; i < pend_n; i++) store_pins[pin_n+i] = pend_pins[i];
    edge_off[e] = pin_n;
    edge_off[e+1] = pin_n + pend_n;
    bnext[e] = bhead[first];
    bhead[first] = e;
    edge_n++;
    pin_n += pend_n;
    for (int i = 0; i < pend_n; i++)
      result_queue.push_back(mk(hcd_pkg::KIND_PIN, e, pend_pins[i], wt,
                                i + 1 == pend_n));
  endtask

  // Predict the results of one accepted input beat.
  task automatic predict_contraction(hcd_pkg::in_beat_t b);
    case (b.cmd)
      hcd_pkg::CMD_LOAD: begin
        map_shadow[b.fine_vertex] = b.mapped_vertex;
      end
      hcd_pkg::CMD_CLEAR: clear_shadow();
      hcd_pkg::CMD_PIN: begin
        add_pending(b.fine_vertex);
        if (b.last_pin) begin
          close_edge(b.edge_weight);
          pend_n = 0; pend_bad = 0;
        end
      end
      default: ;
    endcase
  endtask

  // Driver: presents queued beats with random gaps.
  int gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_contraction(in_data);
        sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (cmd_queue.size() > 0 && !hold_input) begin
          in_data <= cmd_queue.pop_front();
          in_valid <= 1'b1;
          gap = ($urandom_range(0, 9) < 6) ? 0 :
                ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(20, 80);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares result beats and stalls at random.
  int ostall = 0;
  always @(posedge clk) begin
    hcd_pkg::out_beat_t x;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (result_queue.size() == 0) begin
          $error("unexpected result beat kind=%0d", out_data.kind);
          errors++;
        end else begin
          x = result_queue.pop_front();
          if (out_data.kind !== x.kind) begin
            $error("kind expected %0d actual %0d", x.kind, out_data.kind); errors++;
          end
          if (out_data.edge_index !== x.edge_index) begin
            $error("edge_index expected %0d actual %0d", x.edge_index,
                   out_data.edge_index); errors++;
          end
          if (out_data.coarse_pin !== x.coarse_pin) begin
            $error("coarse_pin expected %0d actual %0d", x.coarse_pin,
                   out_data.coarse_pin); errors++;
          end
          if (out_data.weight !== x.weight) begin
            $error("weight expected %0d actual %0d", x.weight, out_data.weight); errors++;
          end
          if (out_data.last !== x.last) begin
            $error("last expected %0d actual %0d", x.last, out_data.last); errors++;
          end
        end
      end
      if (ostall > 0) begin
        ostall--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 9) < 3)
          ostall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(15, 60);
      end
    end
  end

  // Cycle limit.
  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > 10000000) begin
      $display("[hyperedge_contraction_dedup] ERROR");
      $finish;
    end
  end

  task automatic push_beat(logic [1:0] c, int unsigned f, int unsigned m,
                           int unsigned w, bit l);
    hcd_pkg::in_beat_t b;
    b.cmd = c; b.fine_vertex = f[hcd_pkg::VW-1:0]; b.mapped_vertex = m[hcd_pkg::VW-1:0];
    b.edge_weight = w[15:0]; b.last_pin = l;
    cmd_queue.push_back(b);
  endtask

  // Pick a fine vertex whose map entry is loaded.
  int unsigned loaded [$];
  function automatic int unsigned any_loaded();
    return loaded[$urandom_range(0, loaded.size() - 1)];
  endfunction

  task automatic load_map(int unsigned f, int unsigned m);
    push_beat(hcd_pkg::CMD_LOAD, f, m, $urandom, $urandom_range(0, 1));
    loaded.push_back(f);
  endtask

  // Wait for the block to drain, then let the bucket sweep run out.
  task automatic drain();
    while (cmd_queue.size() > 0 || in_valid || result_queue.size() > 0) @(posedge clk);
    repeat (5000) @(posedge clk);
  endtask

  task automatic write_count(int unsigned v);
    @(posedge clk);
    cfg_data <= v[hcd_pkg::CVW-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    vcount = v;
    cfg_valid <= 1'b0;
  endtask

  // A random edge of n pins drawn from the loaded entries.
  task automatic random_edge(int n);
    for (int i = 0; i < n; i++)
      push_beat(hcd_pkg::CMD_PIN, any_loaded(), $urandom, $urandom, i == n - 1);
  endtask

  int unsigned limits [4] = '{4096, 1, 37, 2048};

  initial begin
    vcount = 4096;
    clear_shadow();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (5000) @(posedge clk);

    // Directed: map extremes, duplicates, drop, merge, overflow, an unused command, a clear.
    load_map(0, 0);
    load_map(4095, 4095);
    load_map(1, 0);
    load_map(2, 7);
    push_beat(hcd_pkg::CMD_PIN, 4095, 0, 16'hFFFF, 0);
    push_beat(hcd_pkg::CMD_PIN, 0, 0, 16'hFFFF, 1);
    push_beat(hcd_pkg::CMD_PIN, 1, 0, 0, 0);
    push_beat(hcd_pkg::CMD_PIN, 4095, 0, 0, 1);
    push_beat(hcd_pkg::CMD_PIN, 0, 0, 5, 0);
    push_beat(hcd_pkg::CMD_PIN, 1, 0, 5, 1);
    push_beat(hcd_pkg::CMD_PIN, 2, 0, 9, 1);
    push_beat(CMD_UNUSED, 2, 1, 1, 1);
    for (int i = 0; i < 33; i++) load_map(100 + i, 200 + i);
    for (int i = 0; i < 33; i++) push_beat(hcd_pkg::CMD_PIN, 100 + i, 0, 3, i == 32);
    push_beat(hcd_pkg::CMD_CLEAR, 0, 0, 0, 0);
    push_beat(hcd_pkg::CMD_PIN, 0, 0, 1, 0);
    push_beat(hcd_pkg::CMD_PIN, 4095, 0, 2, 1);
    drain();

    // Random phases over several vertex counts.
    foreach (limits[p]) begin
      write_count(limits[p]);
      while (sent < 85 * (p + 1) + 80) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) load_map($urandom_range(0, 4095), $urandom_range(0, 63));
        else if (r < 17) push_beat(hcd_pkg::CMD_CLEAR, $urandom, $urandom, $urandom,
                                   $urandom);
        else if (r < 19) push_beat(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
        else random_edge($urandom_range(0, 9) < 9 ? $urandom_range(1, 5)
                                                  : $urandom_range(20, 36));
        while (cmd_queue.size() > 8) @(posedge clk);
        if (p == 1 && sent > 200 && !held) begin
          held = 1;
          hold_input = 1;
          while (in_valid || result_queue.size() > 0) @(posedge clk);
          hold_input = 0;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("[hyperedge_contraction_dedup] OK");
    end else begin
      $display("[hyperedge_contraction_dedup] ERROR");
    end
    $finish;
  end

endmodule

// ===== hyperedge_contraction_dedup.f =====
src/hcd_pkg.sv
src/hcd_pending.sv
src/hyperedge_contraction_dedup.sv
tb/tb_top.sv
